>>> sv/lac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg - shared types and constants of the lagged autocorrelation unit
// sizes of the point and lag space, beat layouts and the records that move
// along the row of lag cells
// ----------------------------------------------------------------------------
package lac_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int MAX_LAGS   = 16;

   // fixed field widths
   localparam int POINT_W  = 12;
   localparam int SAMPLE_W = 16;
   localparam int SEL_W    = 4;
   localparam int ACC_W    = 48;
   localparam int TOT_W    = 56;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int DELTA_W  = PROD_W;

   // derived sizes
   localparam int PT_AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LAG_AW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
   localparam int CNT_W  = $clog2(MAX_LAGS + 1);

   // response queue
   localparam int RSP_DEPTH = 32;
   localparam int RSP_AW    = $clog2(RSP_DEPTH);
   localparam int CRED_W    = $clog2(RSP_DEPTH + 1);

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic [ACC_W-1:0] ACC_MAX_V = {1'b0, {(ACC_W - 1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN_V = {1'b1, {(ACC_W - 1){1'b0}}};
   localparam logic [TOT_W-1:0] TOT_MAX_V = {1'b0, {(TOT_W - 1){1'b1}}};
   localparam logic [TOT_W-1:0] TOT_MIN_V = {1'b1, {(TOT_W - 1){1'b0}}};

   // one input beat, unpacked from the stream
   typedef struct packed {
      logic                       is_read;
      logic [POINT_W-1:0]         point;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SEL_W-1:0]           sel;
   } req_beat_type;

   // window state seen by the history front end
   typedef struct packed {
      logic [LAG_AW-1:0] pos;
      logic [CNT_W-1:0]  lags;
      logic [CNT_W-1:0]  frames;
      logic              pt_ok;
   } ring_type;

   // record handed from cell to cell, entry 0 belongs to the receiving cell
   typedef struct packed {
      logic                               valid;
      logic                               is_read;
      logic [PT_AW-1:0]                   point;
      logic signed [SAMPLE_W-1:0]         sample;
      logic [MAX_LAGS-1:0][SAMPLE_W-1:0]  hist;
      logic [MAX_LAGS-1:0]                lag_en;
      logic [MAX_LAGS-1:0]                rd_hit;
   } item_type;

   // result payload, corr_value in the low bits
   typedef struct packed {
      logic [TOT_W-1:0] total;
      logic [ACC_W-1:0] corr;
   } rsp_data_type;

   typedef struct packed {
      logic         valid;
      rsp_data_type data;
   } res_type;

   // accumulator clearing sweep
   typedef struct packed {
      logic             active;
      logic [PT_AW-1:0] addr;
   } clear_type;

endpackage

>>> sv/lac_history.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_history - sample history ring and lag alignment
// one history bank per ring slot, all read at the point of the beat; the
// slots are then rotated into lag order and handed to the first cell
// ----------------------------------------------------------------------------
module lac_history import lac_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_beat_type beat,
   input  ring_type     ring,
   output item_type     item_out
);

   logic [PT_AW-1:0]    addr;
   logic                wr_en;
   logic                rd_ok;
   logic [SAMPLE_W-1:0] rd_bank [MAX_LAGS];

   logic                       f_valid_ff, f_valid_in;
   logic                       f_read_ff;
   logic [PT_AW-1:0]           f_point_ff;
   logic signed [SAMPLE_W-1:0] f_sample_ff;
   logic [LAG_AW-1:0]          f_pos_ff;
   logic [CNT_W-1:0]           f_lags_ff;
   logic [CNT_W-1:0]           f_frames_ff;
   logic [MAX_LAGS-1:0]        f_hit_ff, f_hit_in;

   item_type item_ff, item_in;

   assign addr  = beat.point[PT_AW-1:0];
   assign wr_en = accept && (beat.is_read == REQ_SAMPLE) && ring.pt_ok;
   assign rd_ok = (32'(beat.point) < MAX_POINTS) && (32'(beat.sel) < MAX_LAGS);

   always_comb begin
      f_valid_in = accept && ((beat.is_read == REQ_READ) || ring.pt_ok);
      if ((beat.is_read == REQ_READ) && rd_ok) begin
         f_hit_in = MAX_LAGS'(1) << beat.sel;
      end else begin
         f_hit_in = '0;
      end
   end

   // one bank per ring slot, read-first
   for (genvar g = 0; g < MAX_LAGS; g++) begin : g_bank
      logic [SAMPLE_W-1:0] mem [MAX_POINTS];
      logic [SAMPLE_W-1:0] rdata_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (ring.pos == LAG_AW'(g))) begin
            mem[addr] <= beat.sample;
         end
         rdata_ff <= mem[addr];
      end

      assign rd_bank[g] = rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      f_read_ff   <= beat.is_read;
      f_point_ff  <= addr;
      f_sample_ff <= beat.sample;
      f_pos_ff    <= ring.pos;
      f_lags_ff   <= ring.lags;
      f_frames_ff <= ring.frames;
      f_hit_ff    <= f_hit_in;
   end

   // lag k takes slot (pos - k) mod lags
   always_comb begin
      logic [CNT_W:0] kk;
      logic [CNT_W:0] pp;
      logic [CNT_W:0] ll;
      logic [CNT_W:0] idx;
      pp = (CNT_W + 1)'(f_pos_ff);
      ll = (CNT_W + 1)'(f_lags_ff);
      item_in         = '0;
      item_in.valid   = f_valid_ff;
      item_in.is_read = f_read_ff;
      item_in.point   = f_point_ff;
      item_in.sample  = f_sample_ff;
      item_in.rd_hit  = f_hit_ff;
      for (int k = 1; k <= MAX_LAGS; k++) begin
         kk  = (CNT_W + 1)'(k);
         idx = (pp >= kk) ? (pp - kk) : (pp + ll - kk);
         item_in.hist[k-1]   = rd_bank[idx[LAG_AW-1:0]];
         item_in.lag_en[k-1] = (f_read_ff == REQ_SAMPLE) &&
                               (kk <= (CNT_W + 1)'(f_frames_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;

endmodule

>>> sv/lac_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_cell - one lag of the correlation row
// holds the accumulator bank and the running total of its lag; multiplies,
// accumulates with saturation and passes the record on to the next cell
// ----------------------------------------------------------------------------
module lac_cell import lac_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  clear_type clr,
   input  item_type  item_in,
   input  res_type   res_in,
   output item_type  item_out,
   output res_type   res_out
);

   logic [ACC_W-1:0] acc_mem [MAX_POINTS];
   logic [ACC_W-1:0] acc_rd_ff;

   // stage 1
   item_type             s1_ff, s1_in;
   logic                 s1_act_ff, s1_act_in;
   logic                 s1_hit_ff, s1_hit_in;
   logic [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   logic                 fwd_valid_ff;
   logic [PT_AW-1:0]     fwd_point_ff;
   logic [ACC_W-1:0]     fwd_val_ff;

   logic [ACC_W-1:0]     old_acc;
   logic [ACC_W:0]       acc_sum;
   logic [ACC_W:0]       diff_hi;
   logic [ACC_W:0]       diff_lo;
   logic [ACC_W-1:0]     new_acc;
   logic [DELTA_W-1:0]   delta;
   logic                 mem_we;
   logic [PT_AW-1:0]     mem_wa;
   logic [ACC_W-1:0]     mem_wd;

   // stage 2
   logic                 s2_read_ff;
   logic                 s2_act_ff;
   logic                 s2_hit_ff;
   logic [DELTA_W-1:0]   delta_ff;
   logic [ACC_W-1:0]     accv_ff;

   logic [TOT_W-1:0]     total_ff, total_in;
   logic [TOT_W:0]       tot_sum;
   logic [TOT_W-1:0]     tot_sat;
   res_type              res_ff, res_in_next;

   // stage 0: take own entry, shift the rest down
   always_comb begin
      s1_in        = item_in;
      s1_in.hist   = item_in.hist >> SAMPLE_W;
      s1_in.lag_en = item_in.lag_en >> 1;
      s1_in.rd_hit = item_in.rd_hit >> 1;
      s1_act_in    = item_in.valid && item_in.lag_en[0];
      s1_hit_in    = item_in.valid && item_in.rd_hit[0];
      prod_in      = $signed(item_in.hist[0]) * $signed(item_in.sample);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff     <= '0;
         s1_act_ff <= 1'b0;
         s1_hit_ff <= 1'b0;
      end else begin
         s1_ff     <= s1_in;
         s1_act_ff <= s1_act_in;
         s1_hit_ff <= s1_hit_in;
      end
      prod_ff <= prod_in;
   end

   // stage 1: read-modify-write of the accumulator, last write forwarded
   always_comb begin
      if (fwd_valid_ff && (fwd_point_ff == s1_ff.point)) begin
         old_acc = fwd_val_ff;
      end else begin
         old_acc = acc_rd_ff;
      end
      acc_sum = {old_acc[ACC_W-1], old_acc} +
                {{(ACC_W + 1 - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      diff_hi = {1'b0, ACC_MAX_V} - {old_acc[ACC_W-1], old_acc};
      diff_lo = {1'b1, ACC_MIN_V} - {old_acc[ACC_W-1], old_acc};
      if (acc_sum[ACC_W] == acc_sum[ACC_W-1]) begin
         new_acc = acc_sum[ACC_W-1:0];
         delta   = prod_ff;
      end else if (!acc_sum[ACC_W]) begin
         new_acc = ACC_MAX_V;
         delta   = diff_hi[DELTA_W-1:0];
      end else begin
         new_acc = ACC_MIN_V;
         delta   = diff_lo[DELTA_W-1:0];
      end
   end

   // clearing sweep owns the write port after reset
   always_comb begin
      mem_we = clr.active || s1_act_ff;
      mem_wa = clr.active ? clr.addr : s1_ff.point;
      mem_wd = clr.active ? '0 : new_acc;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[mem_wa] <= mem_wd;
      end
      acc_rd_ff <= acc_mem[item_in.point];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         s2_read_ff   <= 1'b0;
         s2_act_ff    <= 1'b0;
         s2_hit_ff    <= 1'b0;
      end else begin
         fwd_valid_ff <= s1_act_ff;
         s2_read_ff   <= s1_ff.valid && (s1_ff.is_read == REQ_READ);
         s2_act_ff    <= s1_act_ff;
         s2_hit_ff    <= s1_hit_ff;
      end
      fwd_point_ff <= s1_ff.point;
      fwd_val_ff   <= new_acc;
      delta_ff     <= delta;
      accv_ff      <= old_acc;
   end

   // stage 2: lag total and result insertion
   always_comb begin
      tot_sum = {total_ff[TOT_W-1], total_ff} +
                {{(TOT_W + 1 - DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
      if (tot_sum[TOT_W] == tot_sum[TOT_W-1]) begin
         tot_sat = tot_sum[TOT_W-1:0];
      end else if (!tot_sum[TOT_W]) begin
         tot_sat = TOT_MAX_V;
      end else begin
         tot_sat = TOT_MIN_V;
      end
      total_in = s2_act_ff ? tot_sat : total_ff;

      res_in_next.valid = s2_read_ff;
      if (s2_hit_ff) begin
         res_in_next.data.corr  = accv_ff;
         res_in_next.data.total = total_ff;
      end else begin
         res_in_next.data = res_in.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         res_ff   <= '0;
      end else begin
         total_ff <= total_in;
         res_ff   <= res_in_next;
      end
   end

   assign item_out = s1_ff;
   assign res_out  = res_ff;

endmodule

>>> sv/lac_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_rsp_fifo - response queue
// holds finished read results until the result channel takes them; the head
// entry sits in an output register, the rest in a small memory
// ----------------------------------------------------------------------------
module lac_rsp_fifo import lac_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_data_type push_data,
   input  logic         pop,
   output logic         out_valid,
   output rsp_data_type out_data
);

   rsp_data_type      mem [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_AW:0]   count_ff, count_in;
   logic              head_valid_ff, head_valid_in;
   rsp_data_type      head_ff;
   logic              load;
   logic              mem_pop;
   logic              mem_push;

   // head register refills from the memory, or straight from push when empty
   always_comb begin
      load          = !head_valid_ff || pop;
      mem_pop       = load && (count_ff != '0);
      mem_push      = push && !(load && (count_ff == '0));
      head_valid_in = load ? ((count_ff != '0) || push) : head_valid_ff;
      wr_ptr_in     = mem_push ? wr_ptr_ff + RSP_AW'(1) : wr_ptr_ff;
      rd_ptr_in     = mem_pop ? rd_ptr_ff + RSP_AW'(1) : rd_ptr_ff;
      count_in      = count_ff + (RSP_AW + 1)'(mem_push) - (RSP_AW + 1)'(mem_pop);
   end

   always_ff @(posedge clock) begin
      if (mem_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (mem_pop) begin
         head_ff <= mem[rd_ptr_ff];
      end else if (load && push) begin
         head_ff <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         head_valid_ff <= head_valid_in;
      end
   end

   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

endmodule

>>> sv/lagged_autocorrelation_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_autocorrelation_accumulator_unit - per-point lagged autocorrelation
// keeps a history ring per grid point, multiplies each new sample by its
// lagged predecessors and accumulates the products per point and per lag
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata point, sample, lag_sel
//                                              tuser req_type
//   rsp      out        rsp_tvalid/rsp_tready  tdata corr_value, lag_total
//   csr      in         apb, pready tied high  points_in_use @0, lags_in_use @4
//
// one beat per clock is accepted in steady state; a read beat returns its
// result once it has passed the row of lag cells, one cell per lag with
// its own accumulator bank and multiplier
// after reset the accumulator banks are cleared one row per cycle, so
// req_tready stays low until all MAX_POINTS (4096) rows are clear; csr writes go on
// req_tready also drops while RSP_DEPTH (32) read results are outstanding,
// so a stalled result channel holds the input side without losing beats
//
module lagged_autocorrelation_accumulator_unit import lac_pkg::*; (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,    // point [11:0], sample [27:12], lag_sel [31:28]
   input  logic         req_tuser,    // req_type [0]

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,    // corr_value [47:0], lag_total [103:48]

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int PTS_W = 13;
   localparam int LGS_W = 5;

   // register indexes
   localparam logic REG_POINTS = 1'b0;
   localparam logic REG_LAGS   = 1'b1;

   localparam logic [PTS_W-1:0] POINTS_RESET = 13'd4096;
   localparam logic [LGS_W-1:0] LAGS_RESET   = 5'd10;

   // csr registers
   logic [PTS_W-1:0]  points_ff, points_in;
   logic [LGS_W-1:0]  lags_ff, lags_in;
   logic              csr_we;
   logic              csr_index;

   // window state
   logic [LAG_AW-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  frames_ff, frames_in;
   logic [PTS_W-1:0]  np_eff;
   logic [CNT_W-1:0]  lags_eff;

   // clearing sweep
   logic              clear_ff, clear_in;
   logic [PT_AW-1:0]  clr_addr_ff, clr_addr_in;
   clear_type         clr;

   // outstanding read results, in flight or queued
   logic [CRED_W-1:0] credit_ff, credit_in;

   req_beat_type      beat;
   ring_type          ring;
   logic              req_accept;
   logic              rd_accept;
   logic              pt_ok;
   logic              frame_end;
   logic              rsp_pop;

   item_type          chain_item [MAX_LAGS + 1];
   res_type           chain_res  [MAX_LAGS + 1];
   rsp_data_type      rsp_data;

   // beat unpacking
   assign beat.point   = req_tdata[11:0];
   assign beat.sample  = req_tdata[27:12];
   assign beat.sel     = req_tdata[31:28];
   assign beat.is_read = req_tuser;

   assign req_tready = !clear_ff && (credit_ff < CRED_W'(RSP_DEPTH));
   assign req_accept = req_tvalid && req_tready;
   assign rd_accept  = req_accept && (beat.is_read == REQ_READ);
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      points_in = points_ff;
      lags_in   = lags_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_POINTS: points_in = csr_pwdata[PTS_W-1:0];
            REG_LAGS:   lags_in   = csr_pwdata[LGS_W-1:0];
            default:    ;
         endcase
      end
   end

   assign csr_prdata = (csr_index == REG_LAGS) ? 32'(lags_ff) : 32'(points_ff);

   // effective sizes, clamped to the supported range
   always_comb begin
      if (points_ff == '0) begin
         np_eff = PTS_W'(1);
      end else if (points_ff > PTS_W'(MAX_POINTS)) begin
         np_eff = PTS_W'(MAX_POINTS);
      end else begin
         np_eff = points_ff;
      end
      if (lags_ff == '0) begin
         lags_eff = CNT_W'(1);
      end else if (lags_ff > LGS_W'(MAX_LAGS)) begin
         lags_eff = CNT_W'(MAX_LAGS);
      end else begin
         lags_eff = CNT_W'(lags_ff);
      end
   end

   // samples beyond the point count are dropped, the last point ends a frame
   assign pt_ok     = ({1'b0, beat.point} < np_eff);
   assign frame_end = req_accept && (beat.is_read == REQ_SAMPLE) && pt_ok &&
                      ({1'b0, beat.point} == (np_eff - PTS_W'(1)));

   always_comb begin
      pos_in    = pos_ff;
      frames_in = frames_ff;
      if (csr_we) begin
         // any register write restarts the window
         pos_in    = '0;
         frames_in = '0;
      end else if (frame_end) begin
         if ((CNT_W'(pos_ff) + CNT_W'(1)) == lags_eff) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + LAG_AW'(1);
         end
         if (frames_ff < lags_eff) begin
            frames_in = frames_ff + CNT_W'(1);
         end
      end
   end

   // clearing sweep over all accumulator rows
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + PT_AW'(1);
         if (clr_addr_ff == PT_AW'(MAX_POINTS - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   assign clr.active = clear_ff;
   assign clr.addr   = clr_addr_ff;

   assign credit_in = credit_ff + CRED_W'(rd_accept) - CRED_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff   <= POINTS_RESET;
         lags_ff     <= LAGS_RESET;
         pos_ff      <= '0;
         frames_ff   <= '0;
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         credit_ff   <= '0;
      end else begin
         points_ff   <= points_in;
         lags_ff     <= lags_in;
         pos_ff      <= pos_in;
         frames_ff   <= frames_in;
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         credit_ff   <= credit_in;
      end
   end

   // window state as seen by the beat being accepted
   assign ring.pos    = pos_ff;
   assign ring.lags   = lags_eff;
   assign ring.frames = frames_ff;
   assign ring.pt_ok  = pt_ok;

   lac_history u_history (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .beat     (beat),
      .ring     (ring),
      .item_out (chain_item[0])
   );

   assign chain_res[0] = '0;

   // row of lag cells, cell g holds lag g + 1
   for (genvar g = 0; g < MAX_LAGS; g++) begin : g_cell
      lac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clr      (clr),
         .item_in  (chain_item[g]),
         .res_in   (chain_res[g]),
         .item_out (chain_item[g+1]),
         .res_out  (chain_res[g+1])
      );
   end

   lac_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (chain_res[MAX_LAGS].valid),
      .push_data (chain_res[MAX_LAGS].data),
      .pop       (rsp_pop),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule
